[hw/rtl/mfr_pkg.sv]
// Shared types and constants of the fragment reassembler.
// Holds event codes, packet field codes, the command and result structs.
// No dependencies.
`default_nettype none

package mfr_pkg;

    localparam int NUM_SLOTS_DEF    = 8;
    localparam int BUFFER_BYTES_DEF = 1024;

    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] PKT_UNICAST   = 2'd0;
    localparam logic [1:0] PKT_BROADCAST = 2'd1;
    localparam logic [1:0] PKT_SYNC      = 2'd2;

    localparam logic [1:0] UC_DATA = 2'd0;
    localparam logic [1:0] UC_SYN  = 2'd1;
    localparam logic [1:0] UC_ACK  = 2'd2;

    localparam logic [3:0] SYNC_LEVEL1 = 4'h1;
    localparam logic [3:0] SYNC_LEVEL2 = 4'h2;
    localparam logic [3:0] SYNC_LEVEL3 = 4'h4;
    localparam logic [3:0] SYNC_CLEAR  = 4'h8;

    localparam logic [2:0] UC_FRAG_BYTES = 3'd4;
    localparam logic [2:0] BC_FRAG_BYTES = 3'd6;

    typedef logic [3:0] event_kind_t;

    localparam event_kind_t EV_STORED   = 4'd0;
    localparam event_kind_t EV_COMPLETE = 4'd1;
    localparam event_kind_t EV_SYNC1    = 4'd2;
    localparam event_kind_t EV_SYNC2    = 4'd3;
    localparam event_kind_t EV_SYNC3    = 4'd4;
    localparam event_kind_t EV_FREE     = 4'd5;
    localparam event_kind_t EV_SYN      = 4'd6;
    localparam event_kind_t EV_ACK      = 4'd7;
    localparam event_kind_t EV_NOSLOT   = 4'd8;
    localparam event_kind_t EV_BADSYNC  = 4'd9;
    localparam event_kind_t EV_IGNORED  = 4'd10;
    localparam event_kind_t EV_OVERFLOW = 4'd11;
    localparam event_kind_t EV_RELEASED = 4'd12;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        event_kind_t  event_kind;
        logic [2:0]   slot;
        logic [13:0]  channel_id_key;
        logic [9:0]   write_offset;
        logic [2:0]   byte_count;
        logic [47:0]  data_bytes;
        logic [10:0]  message_length;
        logic [2:0]   source_x;
        logic [2:0]   source_y;
        logic [3:0]   source_core;
        logic         is_broadcast;
    } evt_t;

endpackage

`default_nettype wire

[hw/rtl/mfr_if.sv]
// Channel interfaces of the fragment reassembler: packet/command input
// and event output, each with valid/ready and source/sink modports.
// No dependencies.
`default_nettype none

interface mfr_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] rx_key;
    logic [31:0] rx_payload;
    logic [2:0]  release_slot;

    modport source (output valid, opcode, rx_key, rx_payload, release_slot,
                    input ready);
    modport sink   (input valid, opcode, rx_key, rx_payload, release_slot,
                    output ready);
endinterface

interface mfr_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_kind;
    logic [2:0]  slot;
    logic [13:0] channel_id_key;
    logic [9:0]  write_offset;
    logic [2:0]  byte_count;
    logic [47:0] data_bytes;
    logic [10:0] message_length;
    logic [2:0]  source_x;
    logic [2:0]  source_y;
    logic [3:0]  source_core;
    logic        is_broadcast;

    modport source (output valid, event_kind, slot, channel_id_key, write_offset,
                    byte_count, data_bytes, message_length, source_x, source_y,
                    source_core, is_broadcast,
                    input ready);
    modport sink   (input valid, event_kind, slot, channel_id_key, write_offset,
                    byte_count, data_bytes, message_length, source_x, source_y,
                    source_core, is_broadcast,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/multicast_fragment_reassembler_top.sv]
// Fragment reassembler top level: packet/release input channel, event
// output channel, controller and datapath.
// Depends on mfr_pkg, mfr_if, mfr_ctrl and mfr_datapath.
//
// Usage:
//   req carries a received packet (opcode 0: key and payload) or a slot
//   release (opcode 1: release_slot). Every transfer on req yields exactly
//   one transfer on evt, in order.
//   Each item is first captured into the input registers; then its channel
//   key is matched against the slot table, the slot fill is updated and
//   the event register is loaded, which makes the event valid. A new item
//   is taken only after the last one has loaded the event register.
//   The event register decouples the sides: a new item is taken while an
//   event waits. If evt stalls, the item in work holds until the event
//   register frees, and req.ready stays low meanwhile.
//   Reset frees all slots and clears the event valid; slot keys and fills
//   need no clearing since they are read only for slots in use.
`default_nettype none

module multicast_fragment_reassembler_top #(
    parameter int NUM_SLOTS    = mfr_pkg::NUM_SLOTS_DEF,
    parameter int BUFFER_BYTES = mfr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mfr_req_if.sink    req,
    mfr_evt_if.source  evt
);

    mfr_pkg::ctrl_cmd_t cmd;
    mfr_pkg::evt_t      result;

    mfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (evt.valid),
        .out_ready (evt.ready),
        .cmd       (cmd)
    );

    mfr_datapath #(
        .NUM_SLOTS    (NUM_SLOTS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (req.opcode),
        .rx_key       (req.rx_key),
        .rx_payload   (req.rx_payload),
        .release_slot (req.release_slot),
        .result       (result)
    );

    assign evt.event_kind     = result.event_kind;
    assign evt.slot           = result.slot;
    assign evt.channel_id_key = result.channel_id_key;
    assign evt.write_offset   = result.write_offset;
    assign evt.byte_count     = result.byte_count;
    assign evt.data_bytes     = result.data_bytes;
    assign evt.message_length = result.message_length;
    assign evt.source_x       = result.source_x;
    assign evt.source_y       = result.source_y;
    assign evt.source_core    = result.source_core;
    assign evt.is_broadcast   = result.is_broadcast;

endmodule

`default_nettype wire

[hw/rtl/mfr_ctrl.sv]
// Controller of the fragment reassembler: capture/commit sequencing and
// the output valid flag. Depends on mfr_pkg.
`default_nettype none

module mfr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mfr_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign cmd.capture = in_valid && in_ready;
    assign cmd.commit  = (state_reg == ST_EXEC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mfr_datapath.sv]
// Datapath of the fragment reassembler: input capture, slot table with
// key match and fill tracking, event decode and result register.
// Depends on mfr_pkg.
`default_nettype none

module mfr_datapath #(
    parameter int NUM_SLOTS    = mfr_pkg::NUM_SLOTS_DEF,
    parameter int BUFFER_BYTES = mfr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mfr_pkg::ctrl_cmd_t cmd,
    input  wire logic               opcode,
    input  wire logic [31:0]        rx_key,
    input  wire logic [31:0]        rx_payload,
    input  wire logic [2:0]         release_slot,
    output mfr_pkg::evt_t           result
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

    logic              op_reg;
    logic [31:0]       key_reg;
    logic [31:0]       pay_reg;
    logic [2:0]        rel_reg;

    logic              in_use_reg [NUM_SLOTS];
    logic [13:0]       chan_reg   [NUM_SLOTS];
    logic [FILL_W-1:0] fill_reg   [NUM_SLOTS];

    mfr_pkg::evt_t     res_reg;
    mfr_pkg::evt_t     res_next;

    logic [1:0]        pkt_type;
    logic [1:0]        uc_kind;
    logic              bc;
    logic              last;
    logic [2:0]        pad;
    logic [2:0]        max_bytes;
    logic [2:0]        n_bytes;
    logic [13:0]       chan;
    logic              hit_found;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              slot_found;
    logic [SLOT_W-1:0] slot_idx;
    logic [SLOT_W-1:0] rel_idx;
    logic              rel_ok;
    logic [SLOT_W-1:0] rd_idx;
    logic [FILL_W-1:0] rd_fill;
    logic [13:0]       rd_chan;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] fill_new;
    logic              overflow;
    logic [47:0]       raw_data;
    logic [47:0]       data;
    logic              is_frag;
    logic              write_en;
    logic              release_en;

    function automatic mfr_pkg::evt_t put_channel(input mfr_pkg::evt_t e,
                                                  input logic [13:0] c);
        mfr_pkg::evt_t r;
        r                = e;
        r.channel_id_key = c;
        r.source_x       = c[13:11];
        r.source_y       = c[10:8];
        r.source_core    = c[7:4];
        r.is_broadcast   = c[0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            key_reg <= rx_key;
            pay_reg <= rx_payload;
            rel_reg <= release_slot;
        end
    end

    assign pkt_type  = key_reg[31:30];
    assign uc_kind   = key_reg[15:14];
    assign bc        = (pkt_type == mfr_pkg::PKT_BROADCAST);
    assign last      = key_reg[19];
    assign pad       = key_reg[18:16];
    assign max_bytes = bc ? mfr_pkg::BC_FRAG_BYTES : mfr_pkg::UC_FRAG_BYTES;
    assign n_bytes   = !last ? max_bytes : ((pad >= max_bytes) ? 3'd0 : max_bytes - pad);
    assign chan      = bc ? {key_reg[29:20], 4'b0001} : {key_reg[13:4], 4'b0000};

    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (in_use_reg[i] && (chan_reg[i] == chan))
            begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(i);
            end
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign slot_found = hit_found || free_found;
    assign slot_idx   = hit_found ? hit_idx : free_idx;
    assign rel_idx    = SLOT_W'(rel_reg);
    assign rel_ok     = (32'(rel_reg) < 32'(NUM_SLOTS)) && in_use_reg[rel_idx];
    assign rd_idx     = (op_reg == mfr_pkg::OP_RELEASE) ? rel_idx : hit_idx;
    assign rd_fill    = fill_reg[rd_idx];
    assign rd_chan    = chan_reg[rd_idx];
    assign fill_cur   = hit_found ? rd_fill : '0;
    assign overflow   = (32'(fill_cur) + 32'(n_bytes)) > 32'(BUFFER_BYTES);
    assign fill_new   = fill_cur + FILL_W'(n_bytes);
    assign raw_data   = {(bc ? key_reg[15:0] : 16'h0000), pay_reg};

    always_comb
    begin
        for (int b = 0; b < 6; b++)
        begin
            data[8*b +: 8] = (3'(b) < n_bytes) ? raw_data[8*b +: 8] : 8'h00;
        end
    end

    assign is_frag = (op_reg == mfr_pkg::OP_PACKET)
                     && (bc || ((pkt_type == mfr_pkg::PKT_UNICAST)
                                && (uc_kind == mfr_pkg::UC_DATA)));
    assign write_en   = cmd.commit && is_frag && slot_found && !overflow;
    assign release_en = cmd.commit && (op_reg == mfr_pkg::OP_RELEASE) && rel_ok;

    always_comb
    begin
        res_next = '0;
        if (op_reg == mfr_pkg::OP_RELEASE)
        begin
            res_next.slot       = rel_reg;
            res_next.event_kind = mfr_pkg::EV_IGNORED;
            if (rel_ok)
            begin
                res_next                = put_channel(res_next, rd_chan);
                res_next.event_kind     = mfr_pkg::EV_RELEASED;
                res_next.message_length = 11'(32'(rd_fill));
            end
        end
        else if (is_frag)
        begin
            res_next = put_channel(res_next, chan);
            if (!slot_found)
            begin
                res_next.event_kind = mfr_pkg::EV_NOSLOT;
            end
            else
            begin
                res_next.slot         = 3'(slot_idx);
                res_next.write_offset = 10'(32'(fill_cur));
                if (overflow)
                begin
                    res_next.event_kind     = mfr_pkg::EV_OVERFLOW;
                    res_next.message_length = 11'(32'(fill_cur));
                end
                else
                begin
                    res_next.event_kind     = last ? mfr_pkg::EV_COMPLETE
                                                   : mfr_pkg::EV_STORED;
                    res_next.byte_count     = n_bytes;
                    res_next.data_bytes     = data;
                    res_next.message_length = 11'(32'(fill_new));
                end
            end
        end
        else
        begin
            case (pkt_type)
                mfr_pkg::PKT_SYNC:
                begin
                    case (key_reg[3:0])
                        mfr_pkg::SYNC_LEVEL1: res_next.event_kind = mfr_pkg::EV_SYNC1;
                        mfr_pkg::SYNC_LEVEL2: res_next.event_kind = mfr_pkg::EV_SYNC2;
                        mfr_pkg::SYNC_LEVEL3: res_next.event_kind = mfr_pkg::EV_SYNC3;
                        mfr_pkg::SYNC_CLEAR:  res_next.event_kind = mfr_pkg::EV_FREE;
                        default:              res_next.event_kind = mfr_pkg::EV_BADSYNC;
                    endcase
                end
                mfr_pkg::PKT_UNICAST:
                begin
                    case (uc_kind)
                        mfr_pkg::UC_SYN: res_next.event_kind = mfr_pkg::EV_SYN;
                        mfr_pkg::UC_ACK: res_next.event_kind = mfr_pkg::EV_ACK;
                        default:         res_next.event_kind = mfr_pkg::EV_IGNORED;
                    endcase
                end
                default:
                begin
                    res_next.event_kind = mfr_pkg::EV_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                in_use_reg[i] <= 1'b0;
            end
        end
        else if (write_en)
        begin
            in_use_reg[slot_idx] <= 1'b1;
        end
        else if (release_en)
        begin
            in_use_reg[rel_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            chan_reg[slot_idx] <= chan;
            fill_reg[slot_idx] <= fill_new;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

[verif/mfr_event_checker.sv]
// Event checker for the fragment reassembler: predicts one event per packet or
// release transfer from its own slot table and compares each event transfer.
// Depends on mfr_pkg and the mfr_req_if / mfr_evt_if interfaces.
module mfr_event_checker (
    input  logic clk,
    input  logic rst_n,
    mfr_req_if   req,
    mfr_evt_if   evt,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mfr_pkg::*;

    logic        slot_busy [NUM_SLOTS_DEF];
    logic [13:0] slot_chan [NUM_SLOTS_DEF];
    int          slot_fill [NUM_SLOTS_DEF];
    evt_t        expected_events [$];
    evt_t        want;
    int          mismatches = 0;

    assign errors = mismatches;

    function automatic evt_t with_channel(evt_t e, logic [13:0] chan);
        e.channel_id_key = chan;
        e.source_x       = chan[13:11];
        e.source_y       = chan[10:8];
        e.source_core    = chan[7:4];
        e.is_broadcast   = chan[0];
        return e;
    endfunction

    function automatic evt_t store_fragment(logic [31:0] key, logic [31:0] payload,
                                            logic bcast);
        evt_t        e;
        logic [13:0] chan;
        logic [47:0] data;
        logic [63:0] mask;
        int          hit;
        int          maxb;
        int          nbytes;
        int          fill;
        e = '0;
        chan = bcast ? {key[29:20], 4'b0001} : {key[13:4], 4'b0000};
        e = with_channel(e, chan);
        hit = -1;
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
            if (hit < 0 && slot_busy[i] && slot_chan[i] == chan)
                hit = i;
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
            if (hit < 0 && !slot_busy[i])
            begin
                hit          = i;
                slot_busy[i] = 1'b1;
                slot_chan[i] = chan;
                slot_fill[i] = 0;
            end
        if (hit < 0)
        begin
            e.event_kind = EV_NOSLOT;
            return e;
        end
        maxb = bcast ? int'(BC_FRAG_BYTES) : int'(UC_FRAG_BYTES);
        nbytes = maxb;
        if (key[19])
            nbytes = (int'(key[18:16]) >= maxb) ? 0 : maxb - int'(key[18:16]);
        fill = slot_fill[hit];
        e.slot = hit[2:0];
        e.write_offset = fill[9:0];
        if (fill + nbytes > BUFFER_BYTES_DEF)
        begin
            e.event_kind     = EV_OVERFLOW;
            e.message_length = fill[10:0];
            return e;
        end
        data = bcast ? {key[15:0], payload} : {16'h0000, payload};
        mask = (64'd1 << (8 * nbytes)) - 64'd1;
        data = data & mask[47:0];
        fill = fill + nbytes;
        slot_fill[hit] = fill;
        e.event_kind     = key[19] ? EV_COMPLETE : EV_STORED;
        e.byte_count     = nbytes[2:0];
        e.data_bytes     = data;
        e.message_length = fill[10:0];
        return e;
    endfunction

    function automatic evt_t predict_event(logic op, logic [31:0] key,
                                           logic [31:0] payload, logic [2:0] rel);
        evt_t e;
        e = '0;
        if (op == OP_RELEASE)
        begin
            e.slot = rel;
            if (!slot_busy[rel])
                e.event_kind = EV_IGNORED;
            else
            begin
                e = with_channel(e, slot_chan[rel]);
                e.event_kind     = EV_RELEASED;
                e.message_length = slot_fill[rel][10:0];
                slot_busy[rel]   = 1'b0;
            end
            return e;
        end
        case (key[31:30])
            PKT_SYNC:
                case (key[3:0])
                    SYNC_LEVEL1: e.event_kind = EV_SYNC1;
                    SYNC_LEVEL2: e.event_kind = EV_SYNC2;
                    SYNC_LEVEL3: e.event_kind = EV_SYNC3;
                    SYNC_CLEAR:  e.event_kind = EV_FREE;
                    default:     e.event_kind = EV_BADSYNC;
                endcase
            PKT_UNICAST:
                case (key[15:14])
                    UC_DATA: e = store_fragment(key, payload, 1'b0);
                    UC_SYN:  e.event_kind = EV_SYN;
                    UC_ACK:  e.event_kind = EV_ACK;
                    default: e.event_kind = EV_IGNORED;
                endcase
            PKT_BROADCAST:
                e = store_fragment(key, payload, 1'b1);
            default:
                e.event_kind = EV_IGNORED;
        endcase
        return e;
    endfunction

    task automatic check_field(input string name, input logic [47:0] exp_v,
                               input logic [47:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_events.delete();
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
                slot_busy[i] = 1'b0;
            pending <= 0;
        end
        else
        begin
            if (evt.valid && evt.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("event_kind: expected none, actual 0x%0h", evt.event_kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.event_kind, evt.event_kind);
                    check_field("slot", want.slot, evt.slot);
                    check_field("channel_id_key", want.channel_id_key, evt.channel_id_key);
                    check_field("write_offset", want.write_offset, evt.write_offset);
                    check_field("byte_count", want.byte_count, evt.byte_count);
                    check_field("data_bytes", want.data_bytes, evt.data_bytes);
                    check_field("message_length", want.message_length,
                                evt.message_length);
                    check_field("source_x", want.source_x, evt.source_x);
                    check_field("source_y", want.source_y, evt.source_y);
                    check_field("source_core", want.source_core, evt.source_core);
                    check_field("is_broadcast", want.is_broadcast, evt.is_broadcast);
                end
            end
            if (req.valid && req.ready)
                expected_events.push_back(predict_event(req.opcode, req.rx_key,
                                                        req.rx_payload,
                                                        req.release_slot));
            pending <= expected_events.size();
        end
    end
endmodule

[verif/tb.sv]
// Top of the fragment reassembler regression: clock, reset, packet and release
// stimulus with random gaps and event back-pressure, and the verdict.
// Depends on mfr_pkg, the channel interfaces, the block and mfr_event_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mfr_pkg::*;

    localparam logic [1:0] PKT_MULTICAST = 2'd3;
    localparam logic [1:0] UC_RESERVED   = 2'd3;
    localparam int         POOL_SIZE     = 12;

    logic clk;
    logic rst_n;
    logic calm;
    int   errors;
    int   pending;

    logic       pool_bc [POOL_SIZE];
    logic [9:0] pool_id [POOL_SIZE];

    mfr_req_if req ();
    mfr_evt_if evt ();

    multicast_fragment_reassembler_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .evt   (evt)
    );

    mfr_event_checker evt_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .evt     (evt),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #2_000_000;
        $display("multicast_fragment_reassembler_top regression: fail");
        $finish;
    end

    initial
    begin
        evt.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            evt.ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    function automatic logic [31:0] frag_key(logic bcast, logic [9:0] id, logic last,
                                             logic [2:0] pad);
        logic [31:0] k;
        k = $urandom;
        k[19]    = last;
        k[18:16] = pad;
        if (bcast)
        begin
            k[31:30] = PKT_BROADCAST;
            k[29:20] = id;
        end
        else
        begin
            k[31:30] = PKT_UNICAST;
            k[15:14] = UC_DATA;
            k[13:4]  = id;
        end
        return k;
    endfunction

    function automatic logic [31:0] sync_key(logic [3:0] level);
        logic [31:0] k;
        k = $urandom;
        k[31:30] = PKT_SYNC;
        k[3:0]   = level;
        return k;
    endfunction

    function automatic logic [31:0] ctrl_key(logic [1:0] kind);
        logic [31:0] k;
        k = $urandom;
        k[31:30] = PKT_UNICAST;
        k[15:14] = kind;
        return k;
    endfunction

    task automatic send_item(input logic op, input logic [31:0] key,
                             input logic [31:0] payload, input logic [2:0] rel);
        while (!calm && $urandom_range(99) < 16)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.opcode       <= op;
        req.rx_key       <= key;
        req.rx_payload   <= payload;
        req.release_slot <= rel;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    initial
    begin
        int          bid;
        int          pick;
        int          r;
        logic [1:0]  kind;
        logic [3:0]  level;
        req.valid        <= 1'b0;
        req.opcode       <= OP_PACKET;
        req.rx_key       <= '0;
        req.rx_payload   <= '0;
        req.release_slot <= '0;
        calm  <= 1'b0;
        rst_n <= 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_bc[i] = 1'($urandom_range(1));
            pool_id[i] = 10'($urandom);
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_PACKET, sync_key(SYNC_LEVEL1), $urandom, 3'd0);
        send_item(OP_PACKET, sync_key(SYNC_LEVEL2), $urandom, 3'd0);
        send_item(OP_PACKET, sync_key(SYNC_LEVEL3), $urandom, 3'd0);
        send_item(OP_PACKET, sync_key(SYNC_CLEAR), $urandom, 3'd0);
        send_item(OP_PACKET, {PKT_SYNC, 30'h0}, 32'h0, 3'd0);
        send_item(OP_PACKET, ctrl_key(UC_SYN), $urandom, 3'd0);
        send_item(OP_PACKET, ctrl_key(UC_ACK), $urandom, 3'd0);
        send_item(OP_PACKET, ctrl_key(UC_RESERVED), $urandom, 3'd0);
        send_item(OP_PACKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        send_item(OP_RELEASE, $urandom, $urandom, 3'd5);
        send_item(OP_PACKET, frag_key(1'b0, 10'h3FF, 1'b0, 3'd7), 32'hFFFF_FFFF, 3'd0);
        send_item(OP_PACKET, frag_key(1'b0, 10'h3FF, 1'b1, 3'd0), $urandom, 3'd0);
        send_item(OP_PACKET, frag_key(1'b1, 10'h000, 1'b0, 3'd0) | 32'h0000_FFFF,
                  32'h0, 3'd0);
        send_item(OP_PACKET, frag_key(1'b1, 10'h000, 1'b1, 3'd7), $urandom, 3'd0);
        send_item(OP_PACKET, frag_key(1'b0, 10'h000, 1'b1, 3'd4), $urandom, 3'd0);
        send_item(OP_PACKET, frag_key(1'b1, 10'h3FF, 1'b1, 3'd5), $urandom, 3'd0);
        for (int i = 1; i <= 4; i++)
            send_item(OP_PACKET, frag_key(1'b0, 10'(i), 1'b0, 3'd0), $urandom, 3'd0);
        send_item(OP_PACKET, frag_key(1'b0, 10'd5, 1'b0, 3'd0), $urandom, 3'd0);
        send_item(OP_RELEASE, $urandom, $urandom, 3'd0);
        send_item(OP_RELEASE, $urandom, $urandom, 3'd0);
        send_item(OP_RELEASE, $urandom, $urandom, 3'd7);

        // fill one broadcast channel to the buffer limit and past it
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
            send_item(OP_RELEASE, $urandom, $urandom, 3'(i));
        bid = $urandom_range(1023);
        for (int i = 0; i < 170; i++)
            send_item(OP_PACKET, frag_key(1'b1, 10'(bid), 1'b0, 3'($urandom)),
                      $urandom, 3'd0);
        send_item(OP_PACKET, frag_key(1'b1, 10'(bid), 1'b0, 3'd0), $urandom, 3'd0);
        send_item(OP_PACKET, frag_key(1'b1, 10'(bid), 1'b1, 3'd2), $urandom, 3'd0);
        send_item(OP_PACKET, frag_key(1'b1, 10'(bid), 1'b1, 3'd0), $urandom, 3'd0);

        for (int n = 0; n < 800; n++)
        begin
            calm <= (n >= 300 && n < 500);
            r = $urandom_range(99);
            if (r < 55)
            begin
                pick = $urandom_range(POOL_SIZE - 1);
                if ($urandom_range(9) == 0)
                    send_item(OP_PACKET,
                              frag_key(1'($urandom_range(1)), 10'($urandom),
                                       $urandom_range(99) < 15, 3'($urandom)),
                              $urandom, 3'($urandom));
                else
                    send_item(OP_PACKET,
                              frag_key(pool_bc[pick], pool_id[pick],
                                       $urandom_range(99) < 15, 3'($urandom)),
                              $urandom, 3'($urandom));
            end
            else if (r < 70)
                send_item(OP_RELEASE, $urandom, $urandom, 3'($urandom_range(7)));
            else if (r < 80)
            begin
                case ($urandom_range(4))
                    0: level = SYNC_LEVEL1;
                    1: level = SYNC_LEVEL2;
                    2: level = SYNC_LEVEL3;
                    3: level = SYNC_CLEAR;
                    default: level = 4'($urandom);
                endcase
                send_item(OP_PACKET, sync_key(level), $urandom, 3'($urandom));
            end
            else if (r < 90)
            begin
                case ($urandom_range(2))
                    0: kind = UC_SYN;
                    1: kind = UC_ACK;
                    default: kind = UC_RESERVED;
                endcase
                send_item(OP_PACKET, ctrl_key(kind), $urandom, 3'($urandom));
            end
            else if (r < 95)
                send_item(OP_PACKET, {PKT_MULTICAST, 30'(($urandom))}, $urandom,
                          3'($urandom));
            else
                send_item(1'($urandom_range(1)), $urandom, $urandom, 3'($urandom));
        end
        calm <= 1'b0;

        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("multicast_fragment_reassembler_top regression: pass");
        else
            $display("multicast_fragment_reassembler_top regression: fail");
        $finish;
    end
endmodule

[files.f]
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_if.sv
hw/rtl/mfr_ctrl.sv
hw/rtl/mfr_datapath.sv
hw/rtl/multicast_fragment_reassembler_top.sv
verif/mfr_event_checker.sv
verif/tb.sv
